// File: rtl/iirl_pkg.sv
package iirl_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_APPEND = 3'd0;
   localparam logic [2:0] KIND_HEAD   = 3'd1;
   localparam logic [2:0] KIND_AFTER  = 3'd2;
   localparam logic [2:0] KIND_REMOVE = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;
   localparam logic [2:0] KIND_CLEAR  = 3'd5;

   // Response status codes.
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Width of the fill field on the response.
   localparam int FILL_W = 8;

   typedef struct packed {
      logic [2:0]         kind;
      logic [6:0]         position;
      logic signed [31:0] word_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] word_out;
      logic [7:0]         fill;
   } rsp_type;

   // What every cell of the chain does with its stored word this cycle.
   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_REMOVE,
      MODE_CLEAR
   } mode_type;

   // Broadcast command from the controller to all cells.
   typedef struct packed {
      mode_type mode;
      logic     lane_load;
      logic     lane_shift;
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

// File: rtl/indexed_insert_remove_list.sv
// Channel   Direction  Payload    Handshake
// req_      in         req_type   req_valid / req_stall
// rsp_      out        rsp_type   rsp_valid / rsp_stall
//
// Append, insert, remove, clear and refused requests are answered in the edge that
// takes the request, and the cells shift or clear in that same edge.
// A read in range is answered by the read lane, which walks the word down the
// chain one cell per cycle and is registered as the response at cell zero.
// Reset clears the fill count, the stored words and the response valid flag.
// A stalled response holds; a new request is taken in the cycle it drains.
module indexed_insert_remove_list #(
   parameter int CAPACITY = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iirl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iirl_pkg::rsp_type rsp_data
);
   import iirl_pkg::*;

   localparam int UW = $clog2(CAPACITY + 1);
   localparam int WW = (UW > FILL_W) ? UW : FILL_W;

   state_type          state_ff;
   state_type          state_in;
   logic [UW-1:0]      used_ff;
   logic [UW-1:0]      used_in;
   logic [6:0]         count_ff;
   logic [6:0]         count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   cell_cmd_type       cmd;
   logic [WW-1:0]      mark;
   logic               rsp_load;
   logic [1:0]         status;
   logic signed [31:0] read_word;

   logic               req_xfer;
   logic               full;
   logic               in_range;
   logic [WW-1:0]      used_w;
   logic [WW-1:0]      pos_w;
   logic [WW-1:0]      fill_w;

   logic signed [31:0] store_bus [CAPACITY];
   logic signed [31:0] lane_bus  [CAPACITY];

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_xfer  = req_valid && !req_stall;
   assign used_w    = WW'(used_ff);
   assign pos_w     = WW'(req_data.position);
   assign full      = (used_ff == UW'(CAPACITY));
   assign in_range  = (pos_w < used_w);

   // Next state: a read in range walks its word out of the chain.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.kind == KIND_READ && in_range) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Decode the request into a chain command, fill update and response.
   always_comb begin
      cmd       = '{mode: MODE_HOLD, lane_load: 1'b0, lane_shift: 1'b0};
      mark      = '0;
      used_in   = used_ff;
      count_in  = count_ff;
      rsp_load  = 1'b0;
      status    = STATUS_DONE;
      read_word = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_load = 1'b1;
               unique case (req_data.kind) inside
                  KIND_APPEND, KIND_HEAD: begin
                     if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        cmd.mode = MODE_INSERT;
                        mark     = (req_data.kind == KIND_APPEND) ? used_w : '0;
                        used_in  = UW'(used_ff + 1'b1);
                     end
                  end
                  KIND_AFTER: begin
                     if (!in_range) begin
                        status = STATUS_RANGE;
                     end else if (full) begin
                        status = STATUS_FULL;
                     end else begin
                        cmd.mode = MODE_INSERT;
                        mark     = WW'(pos_w + 1'b1);
                        used_in  = UW'(used_ff + 1'b1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (!in_range) begin
                        status = STATUS_RANGE;
                     end else begin
                        cmd.mode = MODE_REMOVE;
                        mark     = pos_w;
                        used_in  = UW'(used_ff - 1'b1);
                     end
                  end
                  KIND_READ: begin
                     if (!in_range) begin
                        status = STATUS_RANGE;
                     end else begin
                        // Response comes when the lane reaches cell zero.
                        rsp_load      = 1'b0;
                        cmd.lane_load = 1'b1;
                        count_in      = req_data.position;
                     end
                  end
                  KIND_CLEAR: begin
                     cmd.mode = MODE_CLEAR;
                     used_in  = '0;
                  end
                  default: status = STATUS_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (count_ff == '0) begin
               rsp_load  = 1'b1;
               read_word = lane_bus[0];
            end else begin
               cmd.lane_shift = 1'b1;
               count_in       = count_ff - 1'b1;
            end
         end
         default: begin
            cmd = '{mode: MODE_HOLD, lane_load: 1'b0, lane_shift: 1'b0};
         end
      endcase
   end

   // Response register.
   assign fill_w       = WW'(used_in);
   assign rsp_data_in  = '{status: status, word_out: read_word, fill: fill_w[FILL_W-1:0]};
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain of cells; the ends see zero words beyond the store.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] left_word;
      logic signed [31:0] right_word;
      logic signed [31:0] right_lane;

      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = store_bus[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
         assign right_lane = '0;
      end else begin : g_inner_right
         assign right_word = store_bus[g+1];
         assign right_lane = lane_bus[g+1];
      end

      iirl_cell #(
         .INDEX (g),
         .WW    (WW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .mark       (mark),
         .new_word   (req_data.word_in),
         .left_word  (left_word),
         .right_word (right_word),
         .right_lane (right_lane),
         .store_q    (store_bus[g]),
         .lane_q     (lane_bus[g])
      );
   end

endmodule

// File: rtl/iirl_cell.sv
module iirl_cell #(
   parameter int INDEX = 0,
   parameter int WW    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  iirl_pkg::cell_cmd_type cmd,
   input  logic [WW-1:0]         mark,
   input  logic signed [31:0]    new_word,
   input  logic signed [31:0]    left_word,
   input  logic signed [31:0]    right_word,
   input  logic signed [31:0]    right_lane,
   output logic signed [31:0]    store_q,
   output logic signed [31:0]    lane_q
);
   import iirl_pkg::*;

   localparam logic [WW-1:0] MY_INDEX = WW'(INDEX);

   logic signed [31:0] store_ff;
   logic signed [31:0] store_in;
   logic signed [31:0] lane_ff;
   logic signed [31:0] lane_in;

   // Inserts take the word from the left neighbor above the gap, removals
   // take it from the right neighbor from the removed place on.
   always_comb begin
      store_in = store_ff;
      case (cmd.mode)
         MODE_INSERT: begin
            if (MY_INDEX > mark) begin
               store_in = left_word;
            end else if (MY_INDEX == mark) begin
               store_in = new_word;
            end
         end
         MODE_REMOVE: begin
            if (MY_INDEX >= mark) begin
               store_in = right_word;
            end
         end
         MODE_CLEAR: store_in = '0;
         default:    store_in = store_ff;
      endcase
   end

   // The read lane snapshots the stored word, then walks toward cell zero.
   always_comb begin
      lane_in = lane_ff;
      if (cmd.lane_load) begin
         lane_in = store_ff;
      end else if (cmd.lane_shift) begin
         lane_in = right_lane;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else begin
         store_ff <= store_in;
      end
      lane_ff <= lane_in;
   end

   assign store_q = store_ff;
   assign lane_q  = lane_ff;

endmodule

// File: rtl/iirl_checker.sv
module iirl_checker #(
   parameter int CAPACITY = 128
) (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input iirl_pkg::rsp_type rsp_data
);
   import iirl_pkg::*;

   localparam int CW = ($clog2(CAPACITY + 1) > FILL_W) ? $clog2(CAPACITY + 1) : FILL_W;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // Only a successful read carries a word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |-> rsp_data.word_out == '0)
      else $error("refused request returned a nonzero word");

   // A full refusal reports a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         rsp_data.fill == CAP_W[FILL_W-1:0])
      else $error("full status with a fill below capacity");

   // A waiting response blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request side open while a response is stalled");

   // No response is shown in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind indexed_insert_remove_list iirl_checker #(
   .CAPACITY (CAPACITY)
) u_iirl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import iirl_pkg::*;

   localparam int DEPTH       = 128;
   localparam int ITEM_TARGET = 1200;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 400;

   // The two request codes that the block leaves unused.
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   // Shapes of the random traffic.
   localparam int MIX_GROW   = 0;
   localparam int MIX_SHRINK = 1;
   localparam int MIX_EVEN   = 2;
   localparam int MIX_READS  = 3;

   // Mirror of the list contents and the replies it owes, in order.
   class list_scoreboard;
      logic signed [31:0] words [DEPTH];
      int                 count;
      int                 peak;
      rsp_type            replies_due [$];
      int                 errors;
      int                 checked;
      int                 reads_done;
      int                 full_refusals;
      int                 range_refusals;

      function new();
         foreach (words[i]) words[i] = '0;
         count = 0;
      endfunction

      // Open a gap at a slot by moving the later words up one place.
      function void open_slot(int slot, logic signed [31:0] w);
         for (int i = count; i > slot; i--) words[i] = words[i - 1];
         words[slot] = w;
         count++;
      endfunction

      // Apply one accepted request and queue the reply it must produce.
      function void apply_request(req_type r);
         rsp_type want;
         logic    full;
         logic    in_range;
         full          = (count >= DEPTH);
         in_range      = (int'(r.position) < count);
         want.status   = STATUS_DONE;
         want.word_out = '0;
         case (r.kind)
            KIND_APPEND: begin
               if (full) want.status = STATUS_FULL;
               else open_slot(count, r.word_in);
            end
            KIND_HEAD: begin
               if (full) want.status = STATUS_FULL;
               else open_slot(0, r.word_in);
            end
            KIND_AFTER: begin
               if (!in_range) want.status = STATUS_RANGE;
               else if (full) want.status = STATUS_FULL;
               else open_slot(int'(r.position) + 1, r.word_in);
            end
            KIND_REMOVE: begin
               if (!in_range) begin
                  want.status = STATUS_RANGE;
               end else begin
                  for (int i = r.position; i + 1 < count; i++) words[i] = words[i + 1];
                  count--;
                  words[count] = '0;
               end
            end
            KIND_READ: begin
               if (!in_range) begin
                  want.status = STATUS_RANGE;
               end else begin
                  want.word_out = words[r.position];
                  reads_done++;
               end
            end
            KIND_CLEAR: begin
               foreach (words[i]) words[i] = '0;
               count = 0;
            end
            default: ;
         endcase
         if (want.status == STATUS_FULL) full_refusals++;
         if (want.status == STATUS_RANGE) range_refusals++;
         if (count > peak) peak = count;
         want.fill = count[7:0];
         replies_due.push_back(want);
      endfunction

      // Compare one reply transfer with the oldest reply owed.
      function void check_reply(rsp_type got);
         rsp_type want;
         if (replies_due.size() == 0) begin
            errors++;
            $display("%0t: reply with none owed, status %0d word %0d fill %0d",
                     $time, got.status, got.word_out, got.fill);
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
         end
         if (got.word_out !== want.word_out) begin
            errors++;
            $display("%0t: word_out mismatch, expected %0d, got %0d",
                     $time, want.word_out, got.word_out);
         end
         if (got.fill !== want.fill) begin
            errors++;
            $display("%0t: fill mismatch, expected %0d, got %0d",
                     $time, want.fill, got.fill);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   list_scoreboard sb = new();
   int             cycle_count = 0;
   logic           calm = 1'b0;
   int             items_sent = 0;

   indexed_insert_remove_list #(.CAPACITY(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle counter and run limit.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run limit of %0d cycles reached with %0d replies still owed.",
               CYCLE_LIMIT, sb.replies_due.size());
      $display("TEST FAILED");
      $finish;
   end

   // Every reply transfer is checked against the list mirror.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_reply(rsp_data);
   end

   function automatic req_type make_req(logic [2:0] kind, logic [6:0] position,
                                        logic signed [31:0] word);
      req_type r;
      r.kind     = kind;
      r.position = position;
      r.word_in  = word;
      return r;
   endfunction

   // Offer one request after a random gap and note it once it transfers.
   task automatic send_request(req_type r);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.apply_request(r);
      if (r.kind != KIND_SPARE_A && r.kind != KIND_SPARE_B) items_sent++;
   endtask

   // Draw a request whose shape depends on the traffic mix and the fill.
   function automatic req_type pick_request(int mix, int fill);
      req_type    r;
      int         cut [6];
      int         roll;
      logic [2:0] kinds [6];
      kinds = '{KIND_APPEND, KIND_HEAD, KIND_AFTER, KIND_REMOVE, KIND_READ, KIND_CLEAR};
      case (mix)
         MIX_GROW:   cut = '{40, 60, 80, 88, 96, 97};
         MIX_SHRINK: cut = '{8, 14, 22, 72, 92, 93};
         MIX_EVEN:   cut = '{18, 30, 46, 66, 92, 94};
         default:    cut = '{8, 14, 22, 32, 94, 95};
      endcase
      roll   = $urandom_range(0, 99);
      r.kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
      for (int i = 5; i >= 0; i--) begin
         if (roll < cut[i]) r.kind = kinds[i];
      end
      // Mostly valid positions, with some anywhere in the field.
      if (fill == 0 || $urandom_range(0, 9) == 0) r.position = 7'($urandom());
      else r.position = 7'($urandom_range(0, fill - 1));
      case ($urandom_range(0, 15))
         0:       r.word_in = 32'sh8000_0000;
         1:       r.word_in = 32'sh7fff_ffff;
         2:       r.word_in = '0;
         3:       r.word_in = -32'sd1;
         default: r.word_in = $urandom();
      endcase
      return r;
   endfunction

   // Reply side: random stalls, calm stretches and one long hold-off.
   initial begin
      int   hold;
      logic held_long;
      held_long = 1'b0;
      wait (!reset);
      forever begin
         if (!held_long && sb.checked >= 300) begin
            held_long = 1'b1;
            hold = LONG_HOLD;
         end else begin
            hold = calm ? 0 : $urandom_range(0, 14);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus: directed corner cases, then shaped random traffic.
   initial begin
      int mix;
      int span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty list refuses every positional request.
      send_request(make_req(KIND_READ, 7'd0, 32'sd5));
      send_request(make_req(KIND_REMOVE, 7'd0, 32'sd5));
      send_request(make_req(KIND_AFTER, 7'd0, 32'sd5));
      // Extremes of the word, at both ends and in the middle.
      send_request(make_req(KIND_APPEND, 7'd0, 32'sh7fff_ffff));
      send_request(make_req(KIND_APPEND, 7'd127, 32'sh8000_0000));
      send_request(make_req(KIND_HEAD, 7'd0, -32'sd1));
      send_request(make_req(KIND_HEAD, 7'd0, 32'sd0));
      send_request(make_req(KIND_AFTER, 7'd1, 32'sh5a5a_5a5a));
      send_request(make_req(KIND_AFTER, 7'd4, 32'sd1));
      send_request(make_req(KIND_READ, 7'd0, 32'sd0));
      send_request(make_req(KIND_READ, 7'd5, 32'sd0));
      // Positions at and beyond the fill are refused.
      send_request(make_req(KIND_READ, 7'd6, 32'sd0));
      send_request(make_req(KIND_READ, 7'd127, 32'sd0));
      send_request(make_req(KIND_AFTER, 7'd6, 32'sd9));
      // Remove the top, the bottom and a middle word.
      send_request(make_req(KIND_REMOVE, 7'd5, 32'sd0));
      send_request(make_req(KIND_REMOVE, 7'd0, 32'sd0));
      send_request(make_req(KIND_REMOVE, 7'd1, 32'sd0));
      send_request(make_req(KIND_READ, 7'd1, 32'sd0));
      // The unused codes change nothing.
      send_request(make_req(KIND_SPARE_A, 7'd127, 32'sh7fff_ffff));
      send_request(make_req(KIND_SPARE_B, 7'd0, 32'sh8000_0000));
      // Clear, then the list starts over from empty.
      send_request(make_req(KIND_CLEAR, 7'd3, 32'sd3));
      send_request(make_req(KIND_READ, 7'd0, 32'sd0));
      send_request(make_req(KIND_APPEND, 7'd0, 32'sd42));
      send_request(make_req(KIND_READ, 7'd0, 32'sd0));

      // The first random stretch uses the mix that leans toward growing the list.
      mix  = MIX_GROW;
      span = 200;
      while (items_sent < ITEM_TARGET) begin
         calm <= ($urandom_range(0, 3) == 0);
         for (int j = 0; j < span && items_sent < ITEM_TARGET; j++)
            send_request(pick_request(mix, sb.count));
         mix  = $urandom_range(MIX_GROW, MIX_READS);
         span = $urandom_range(60, 200);
      end
      req_valid <= 1'b0;

      // Drain the owed replies, then watch for strays.
      while (sb.replies_due.size() != 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);

      $display("Sent %0d requests and checked %0d replies: %0d reads returned words,",
               items_sent, sb.checked, sb.reads_done);
      $display("%0d refused as full, %0d out of range, fill peaked at %0d of %0d.",
               sb.full_refusals, sb.range_refusals, sb.peak, DEPTH);
      if (sb.errors == 0 && sb.replies_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: indexed_insert_remove_list.f
rtl/iirl_pkg.sv
rtl/iirl_cell.sv
rtl/indexed_insert_remove_list.sv
rtl/iirl_checker.sv
bench/tb.sv
